FILE: rtl/assert_macros.svh
// Assertion macros used by the top-level formatter unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset.
`define IFF_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);

// Checked at every edge, reset included.
`define IFF_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

FILE: rtl/iff_pkg.sv
// Types, codes and constants of the integer field formatter.
package iff_pkg;

  localparam int DEF_MAX_WIDTH     = 60;
  localparam int DEF_MAX_PRECISION = 40;

  localparam int VAL_W  = 64;               // pointer value width
  localparam int NUM_W  = 32;               // numeric modes width
  localparam int NIB_N  = VAL_W / 4;        // digit slots
  localparam int CNT_W  = 7;                // character counts and positions
  localparam int STEP_W = $clog2(NUM_W);    // conversion step counter
  localparam int NDIG_W = $clog2(NIB_N) + 1;
  localparam int DP_W   = $clog2(NIB_N);

  typedef enum logic [2:0] {
    MODE_SDEC = 3'd0,
    MODE_UDEC = 3'd1,
    MODE_LHEX = 3'd2,
    MODE_UHEX = 3'd3,
    MODE_PTR  = 3'd4
  } mode_t;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_NUL     = 8'h00;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIZE,
    ST_PLAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic conv;
    logic size;
    logic plan;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_dec;
    logic conv_last;
    logic emit_last;
    logic out_free;
  } stat_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
    logic [7:0] base;
    base = upper ? CH_UPPER_A : CH_LOWER_A;
    if (nib < 4'd10) return CH_ZERO + {4'd0, nib};
    else return base + {4'd0, nib} - 8'd10;
  endfunction

endpackage

FILE: rtl/integer_field_formatter_unit.sv
// Integer field formatter: printf-style integer conversion, one character per beat.
//
// Input channel (in_*): one conversion request per beat: mode, 64-bit value,
// flags, width and precision (negative precision means none given).
// Output channel (out_*): the characters of the field in order, one per beat;
// the final beat has out_last set and carries out_total_count. An empty field
// gives a single beat with out_char_valid low and out_last high.
// Flow: decimal modes run a binary to BCD shift loop over the 32-bit magnitude
// and then the size and plan steps; hex and pointer modes skip the loop. The
// characters then follow at one per cycle while out_ready does not hold the
// output. One request is worked at a time; a field holds at most 60 characters.
// in_ready is high only between requests; the next request may be accepted
// while the last character still sits in the output register.
// When out_ready is low the output register holds its beat and emission pauses.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops out_valid.
`include "assert_macros.svh"

module integer_field_formatter_unit import iff_pkg::*; #(
  parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
  parameter int MAX_PRECISION = DEF_MAX_PRECISION
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_mode,
  input  logic [63:0]       in_value,
  input  logic              in_left_align,
  input  logic              in_zero_pad,
  input  logic              in_plus_sign,
  input  logic              in_space_sign,
  input  logic [5:0]        in_width,
  input  logic signed [6:0] in_precision,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_character,
  output logic              out_char_valid,
  output logic              out_last,
  output logic [5:0]        out_total_count
);

  cmd_t  cmd;
  stat_t stat;

  iff_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  iff_dpath #(
    .MAX_WIDTH     (MAX_WIDTH),
    .MAX_PRECISION (MAX_PRECISION)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_mode         (in_mode),
    .in_value        (in_value),
    .in_left_align   (in_left_align),
    .in_zero_pad     (in_zero_pad),
    .in_plus_sign    (in_plus_sign),
    .in_space_sign   (in_space_sign),
    .in_width        (in_width),
    .in_precision    (in_precision),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_character   (out_character),
    .out_char_valid  (out_char_valid),
    .out_last        (out_last),
    .out_total_count (out_total_count)
  );

  `IFF_ASSERT(a_busy_after_accept, clk, rst_n, (in_valid && in_ready) |=> !in_ready, "accepted a second request back to back")
  `IFF_ASSERT(a_empty_is_last, clk, rst_n, (out_valid && !out_char_valid) |-> out_last, "empty-field beat without last")
  `IFF_ASSERT(a_count_on_last, clk, rst_n, (out_valid && out_last) |-> ((out_total_count != 6'd0) == out_char_valid), "total count disagrees with char_valid")
  `IFF_ASSERT_ALWAYS(a_reset_drops_out, clk, !rst_n |=> !out_valid, "out_valid high after reset")

endmodule

FILE: rtl/iff_ctrl.sv
// Sequencer of the formatter: load, convert, size, plan, emit.
module iff_ctrl import iff_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (stat.is_dec) begin
          cmd.conv = 1'b1;
          if (stat.conv_last) state_nxt = ST_SIZE;
        end else begin
          state_nxt = ST_SIZE;
        end
      end
      ST_SIZE: begin
        cmd.size  = 1'b1;
        state_nxt = ST_PLAN;
      end
      ST_PLAN: begin
        cmd.plan  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit = stat.out_free;
        if (stat.out_free && stat.emit_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/iff_dpath.sv
// Datapath: operand registers, binary to BCD shifter, field sizing, output register.
module iff_dpath import iff_pkg::*; #(
  parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
  parameter int MAX_PRECISION = DEF_MAX_PRECISION
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output stat_t             stat,
  input  logic [2:0]        in_mode,
  input  logic [VAL_W-1:0]  in_value,
  input  logic              in_left_align,
  input  logic              in_zero_pad,
  input  logic              in_plus_sign,
  input  logic              in_space_sign,
  input  logic [5:0]        in_width,
  input  logic signed [6:0] in_precision,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_character,
  output logic              out_char_valid,
  output logic              out_last,
  output logic [5:0]        out_total_count
);

  // item operands
  logic [2:0]        mode_r;
  logic              la_r, zp_r, has_prec_r;
  logic [5:0]        w_r, p_r;
  logic [1:0]        npre_r;
  logic [7:0]        pre0_r, pre1_r;
  logic [VAL_W-1:0]  dig_r, dig_nxt;
  logic [NUM_W-1:0]  sh_r;
  logic [STEP_W-1:0] step_r;

  // sizing and plan
  logic [NDIG_W-1:0] ndig_r;
  logic [CNT_W-1:0]  lz_r, pad_r, total_r;
  logic [CNT_W-1:0]  b1_r, b2_r, b3_r, b4_r, k_r;
  logic [DP_W-1:0]   dp_r;

  // output register
  logic              out_valid_r;
  logic [7:0]        out_char_r;
  logic              out_cv_r, out_last_r;
  logic [5:0]        out_cnt_r;

  // load-side decode
  logic [NUM_W-1:0]  low, mag;
  logic              neg;
  logic [5:0]        w_sat, p_sat;

  always_comb begin
    low   = in_value[NUM_W-1:0];
    neg   = (in_mode == MODE_SDEC) && low[NUM_W-1];
    mag   = neg ? (NUM_W'(0) - low) : low;
    w_sat = ({1'b0, in_width} > 7'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : in_width;
    p_sat = ({1'b0, in_precision[5:0]} > 7'(MAX_PRECISION)) ?
            6'(MAX_PRECISION) : in_precision[5:0];
  end

  // one double-dabble step: add 3 to every BCD digit >= 5, then shift in a bit
  always_comb begin
    dig_nxt = dig_r;
    for (int i = 0; i < NIB_N; i++) begin
      if (dig_r[4*i +: 4] >= 4'd5) dig_nxt[4*i +: 4] = dig_r[4*i +: 4] + 4'd3;
    end
    dig_nxt = {dig_nxt[VAL_W-2:0], sh_r[NUM_W-1]};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r     <= in_mode;
      la_r       <= in_left_align;
      zp_r       <= in_zero_pad;
      has_prec_r <= !in_precision[6];
      w_r        <= w_sat;
      p_r        <= p_sat;
      sh_r       <= mag;
      step_r     <= '0;
      npre_r     <= 2'd0;
      pre0_r     <= CH_SPACE;
      pre1_r     <= CH_LOWER_X;
      if (in_mode == MODE_PTR) begin
        npre_r <= 2'd2;
        pre0_r <= CH_ZERO;
      end else if (in_mode == MODE_SDEC) begin
        if (neg) begin
          npre_r <= 2'd1;
          pre0_r <= CH_MINUS;
        end else if (in_plus_sign) begin
          npre_r <= 2'd1;
          pre0_r <= CH_PLUS;
        end else if (in_space_sign) begin
          npre_r <= 2'd1;
        end
      end
      if (in_mode == MODE_PTR) dig_r <= in_value;
      else if (in_mode == MODE_LHEX || in_mode == MODE_UHEX) dig_r <= VAL_W'(mag);
      else dig_r <= '0;
    end else if (cmd.conv) begin
      dig_r  <= dig_nxt;
      sh_r   <= {sh_r[NUM_W-2:0], 1'b0};
      step_r <= step_r + 1'b1;
    end
  end

  // field sizing
  logic              is_num, is_ptr;
  logic [NDIG_W-1:0] ndig_raw, ndig;
  logic [CNT_W-1:0]  ndig7, npre7, w7, p7, lzp, core0, lz, core, pad;

  always_comb begin
    is_num   = (mode_r == MODE_SDEC) || (mode_r == MODE_UDEC) ||
               (mode_r == MODE_LHEX) || (mode_r == MODE_UHEX);
    is_ptr   = (mode_r == MODE_PTR);
    ndig_raw = NDIG_W'(1);
    for (int i = 0; i < NIB_N; i++) begin
      if (dig_r[4*i +: 4] != 4'd0) ndig_raw = NDIG_W'(i + 1);
    end
    if (!(is_num || is_ptr)) ndig = '0;
    else if (is_num && has_prec_r && p_r == 6'd0 && dig_r == '0) ndig = '0;
    else ndig = ndig_raw;
    ndig7 = CNT_W'(ndig);
    npre7 = CNT_W'(npre_r);
    w7    = CNT_W'(w_r);
    p7    = CNT_W'(p_r);
    lzp   = (is_num && has_prec_r && p7 > ndig7) ? (p7 - ndig7) : '0;
    core0 = npre7 + ndig7;
    lz    = (is_num && zp_r && !la_r && !has_prec_r && w7 > core0) ? (w7 - core0) : lzp;
    core  = core0 + lz;
    pad   = (w7 > core) ? (w7 - core) : '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.size) begin
      ndig_r  <= ndig;
      lz_r    <= lz;
      pad_r   <= pad;
      total_r <= core + pad;
    end
    if (cmd.plan) begin
      b1_r <= la_r ? '0 : pad_r;
      b2_r <= (la_r ? '0 : pad_r) + npre7;
      b3_r <= (la_r ? '0 : pad_r) + npre7 + lz_r;
      b4_r <= total_r - (la_r ? pad_r : '0);
      dp_r <= DP_W'(ndig_r - 1'b1);
      k_r  <= '0;
    end else if (cmd.emit) begin
      k_r <= k_r + 1'b1;
      if (k_r >= b3_r && k_r < b4_r) dp_r <= dp_r - 1'b1;
    end
  end

  // character at position k
  logic [7:0] ch;
  logic       empty, last_beat;

  always_comb begin
    empty     = (total_r == '0);
    last_beat = empty || (k_r == total_r - 1'b1);
    if (k_r < b1_r) ch = CH_SPACE;
    else if (k_r < b2_r) ch = (k_r == b1_r) ? pre0_r : pre1_r;
    else if (k_r < b3_r) ch = CH_ZERO;
    else if (k_r < b4_r) ch = hex_char(dig_r[4*dp_r +: 4], mode_r == MODE_UHEX);
    else ch = CH_SPACE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.emit) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_char_r <= empty ? CH_NUL : ch;
      out_cv_r   <= !empty;
      out_last_r <= last_beat;
      out_cnt_r  <= last_beat ? total_r[5:0] : 6'd0;
    end
  end

  always_comb begin
    stat.is_dec    = (mode_r == MODE_SDEC) || (mode_r == MODE_UDEC);
    stat.conv_last = (step_r == STEP_W'(NUM_W - 1));
    stat.emit_last = last_beat;
    stat.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid       = out_valid_r;
  assign out_character   = out_char_r;
  assign out_char_valid  = out_cv_r;
  assign out_last        = out_last_r;
  assign out_total_count = out_cnt_r;

endmodule
